/* rtl/cst_pkg.sv */
package cst_pkg;

    localparam int SLOT_W = 5;
    localparam int GEN_W  = 8;
    localparam int PAY_W  = 32;
    localparam int CNT_W  = 6;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_RESOLVE = 3'd1,
        OP_CONSUME = 3'd2,
        OP_ABANDON = 3'd3,
        OP_CANCEL  = 3'd4,
        OP_QUERY   = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        OC_OK      = 3'd0,
        OC_DROPPED = 3'd1,
        OC_INVALID = 3'd2,
        OC_TIMEOUT = 3'd3,
        OC_FULL    = 3'd4
    } t_outcome;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_PENDING   = 3'd1,
        PH_COMPLETED = 3'd2,
        PH_DROPPED   = 3'd3,
        PH_TIMEOUT   = 3'd4,
        PH_ABANDONED = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]        op;
        logic [SLOT_W-1:0] slot;
        logic [GEN_W-1:0]  generation;
        logic [PAY_W-1:0]  payload;
        logic signed [31:0] status_word;
        logic              drop;
    } t_in;

    typedef struct packed {
        logic [2:0]        outcome;
        logic [SLOT_W-1:0] out_slot;
        logic [GEN_W-1:0]  out_generation;
        logic [PAY_W-1:0]  res_payload;
        logic signed [31:0] res_status;
        logic              notify;
        logic              active;
    } t_out;

    // per-slot record held in the slot memory
    typedef struct packed {
        logic [GEN_W-1:0] gen;
        logic             p_hold;
        logic             c_hold;
        logic [2:0]       phase;
        logic [31:0]      status;
    } t_rec;

endpackage

/* rtl/completion_slot_table_top.sv */
// Order: an input transfer starts the slot memory read; the update then goes into the output
// register. No new item is taken while the slot memory read-modify-write runs or while
// the result waits to be taken; o_stall is high meanwhile.
// Reset: synchronous active low; a clearing pass writes every slot record
// (generation 1, idle) before the first item is taken. slot_count resets to 32.
module completion_slot_table_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  cst_pkg::t_in        i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output cst_pkg::t_out       o_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [5:0]          i_cfg_data
);
    import cst_pkg::*;

    t_rec              r_mem [32];
    logic [PAY_W-1:0]  r_pay [32];
    t_rec              r_rd;
    logic [PAY_W-1:0]  r_rd_pay;

    t_state            r_state, n_state;
    logic [31:0]       r_alloc, n_alloc;
    logic [CNT_W-1:0]  r_count;
    logic [SLOT_W-1:0] r_clr;
    t_in               r_in;
    logic [SLOT_W-1:0] r_sel;
    logic              r_full;
    logic              r_ovalid;
    t_out              r_out, n_out;

    logic [5:0]        usable;
    logic [31:0]       avail;
    logic [SLOT_W-1:0] pick;
    logic              found;
    logic              we, we_pay;
    t_rec              wr_rec;
    logic              in_xfer;

    assign usable = (r_count > 6'd32) ? 6'd32 : r_count;
    assign o_cfg_ready = 1'b1;
    assign o_stall = (r_state != ST_IDLE);
    assign in_xfer = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_data = r_out;

    always_comb begin
        avail = ~r_alloc;
        for (int i = 0; i < 32; i++) begin
            if (i >= int'(usable)) begin
                avail[i] = 1'b0;
            end
        end
        pick = '0;
        found = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (avail[i]) begin
                pick = SLOT_W'(i);
                found = 1'b1;
            end
        end
    end

    always_comb begin
        case (r_state)
            ST_CLEAR: n_state = (r_clr == 5'd31) ? ST_IDLE : ST_CLEAR;
            ST_IDLE:  n_state = in_xfer ? ST_READ : ST_IDLE;
            ST_READ:  n_state = ST_DONE;
            ST_DONE:  n_state = (r_ovalid && i_stall) ? ST_DONE : ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        logic ok, match;
        logic [GEN_W-1:0] ng;
        t_rec rec;
        rec = r_rd;
        n_out = '0;
        n_out.outcome = OC_INVALID;
        n_alloc = r_alloc;
        we = 1'b0;
        we_pay = 1'b0;
        match = ({1'b0, r_in.slot} < usable) && (r_in.generation != '0)
                && (r_rd.gen == r_in.generation);
        ng = (r_rd.gen == '1) ? GEN_W'(1) : r_rd.gen + GEN_W'(1);
        ok = 1'b0;
        case (t_op'(r_in.op))
            OP_CREATE: begin
                if (r_full) begin
                    n_out.outcome = OC_FULL;
                end else begin
                    n_out.outcome = OC_OK;
                    n_out.out_slot = r_sel;
                    n_out.out_generation = r_rd.gen;
                    rec.status = '0;
                    rec.phase = PH_PENDING;
                    rec.p_hold = 1'b1;
                    rec.c_hold = 1'b1;
                    n_alloc[r_sel] = 1'b1;
                    we = 1'b1;
                end
            end
            OP_RESOLVE: begin
                if (match && r_rd.p_hold) begin
                    n_out.outcome = OC_OK;
                    if (r_rd.phase == PH_PENDING) begin
                        rec.status = r_in.status_word;
                        we_pay = !r_in.drop;
                        rec.phase = r_in.drop ? PH_DROPPED : PH_COMPLETED;
                        n_out.notify = 1'b1;
                    end
                    rec.p_hold = 1'b0;
                    ok = !r_rd.c_hold;
                    we = 1'b1;
                end
            end
            OP_CONSUME: begin
                if (match && r_rd.c_hold) begin
                    if (r_rd.phase == PH_COMPLETED) begin
                        n_out.outcome = OC_OK;
                        n_out.res_payload = r_rd_pay;
                        n_out.res_status = r_rd.status;
                    end else if (r_rd.phase == PH_DROPPED) begin
                        n_out.outcome = OC_DROPPED;
                        n_out.res_status = r_rd.status;
                    end else begin
                        n_out.outcome = OC_TIMEOUT;
                        if (r_rd.phase == PH_PENDING) begin
                            rec.phase = PH_TIMEOUT;
                        end
                    end
                    rec.c_hold = 1'b0;
                    ok = !r_rd.p_hold;
                    we = 1'b1;
                end
            end
            OP_ABANDON: begin
                if (match && r_rd.c_hold) begin
                    n_out.outcome = OC_OK;
                    if (r_rd.phase == PH_PENDING) begin
                        rec.phase = PH_ABANDONED;
                    end
                    rec.c_hold = 1'b0;
                    ok = !r_rd.p_hold;
                    we = 1'b1;
                end
            end
            OP_CANCEL: begin
                if (match && r_rd.p_hold && r_rd.c_hold) begin
                    n_out.outcome = OC_OK;
                    ok = 1'b1;
                    we = 1'b1;
                end
            end
            OP_QUERY: begin
                n_out.outcome = OC_OK;
                n_out.active = match && r_rd.p_hold && r_rd.c_hold
                               && (r_rd.phase == PH_PENDING);
            end
            default: ;
        endcase
        // recycle: advance generation, drop holds, free the slot
        if (ok) begin
            rec.gen = ng;
            rec.phase = PH_IDLE;
            rec.p_hold = 1'b0;
            rec.c_hold = 1'b0;
            n_alloc[r_sel] = 1'b0;
        end
        wr_rec = rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_alloc <= '0;
            r_count <= 6'd32;
            r_clr <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 5'd1;
            end
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end
            if (r_state == ST_READ) begin
                r_alloc <= n_alloc;
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_data;
            r_sel <= (t_op'(i_data.op) == OP_CREATE) ? pick : i_data.slot;
            r_full <= !found;
        end
        if (r_state == ST_READ) begin
            r_out <= n_out;
        end
    end

    // slot memories: one read, one write port
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            r_mem[r_clr] <= '{gen: GEN_W'(1), p_hold: 1'b0, c_hold: 1'b0,
                             phase: PH_IDLE, status: '0};
        end else if (r_state == ST_READ && we) begin
            r_mem[r_sel] <= wr_rec;
        end
        r_rd <= r_mem[(in_xfer && t_op'(i_data.op) == OP_CREATE) ? pick : i_data.slot];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ && we_pay) begin
            r_pay[r_sel] <= r_in.payload;
        end
        r_rd_pay <= r_pay[(in_xfer && t_op'(i_data.op) == OP_CREATE) ? pick : i_data.slot];
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !in_xfer) else $error("accept while busy");
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> o_valid) else $error("missing result");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data))) else $error("result lost");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
    import cst_pkg::*;

    class slot_table_scoreboard;
        logic [5:0]  slot_count;
        logic [31:0] allocated;
        logic [7:0]  slot_gen [32];
        logic        p_hold [32];
        logic        c_hold [32];
        t_phase      phase [32];
        logic [31:0] status [32];
        logic [31:0] payload [32];
        t_out        expected_results [$];
        int          errors;

        function new();
            slot_count = 6'd32;
            allocated  = '0;
            errors     = 0;
            for (int i = 0; i < 32; i++) begin
                slot_gen[i] = 8'd1;
                p_hold[i]   = 1'b0;
                c_hold[i]   = 1'b0;
                phase[i]    = PH_IDLE;
                status[i]   = '0;
                payload[i]  = '0;
            end
        endfunction

        function int usable();
            return (slot_count > 6'd32) ? 32 : int'(slot_count);
        endfunction

        function bit handle_ok(int s, logic [7:0] g);
            return s < usable() && g != 8'd0 && slot_gen[s] == g;
        endfunction

        function void recycle(int s);
            slot_gen[s]  = (slot_gen[s] == 8'hFF) ? 8'd1 : slot_gen[s] + 8'd1;
            phase[s]     = PH_IDLE;
            p_hold[s]    = 1'b0;
            c_hold[s]    = 1'b0;
            allocated[s] = 1'b0;
        endfunction

        function void note_input(t_in it);
            t_out r;
            int   s;
            r = '0;
            r.outcome = OC_INVALID;
            s = int'(it.slot);
            case (it.op)
                OP_CREATE: begin
                    r.outcome = OC_FULL;
                    for (int i = 0; i < usable(); i++) begin
                        if (!allocated[i]) begin
                            allocated[i] = 1'b1;
                            status[i]    = '0;
                            phase[i]     = PH_PENDING;
                            p_hold[i]    = 1'b1;
                            c_hold[i]    = 1'b1;
                            r.out_slot       = i[4:0];
                            r.out_generation = slot_gen[i];
                            r.outcome        = OC_OK;
                            break;
                        end
                    end
                end
                OP_RESOLVE: if (handle_ok(s, it.generation) && p_hold[s]) begin
                    r.outcome = OC_OK;
                    if (phase[s] == PH_PENDING) begin
                        status[s] = it.status_word;
                        if (!it.drop) payload[s] = it.payload;
                        phase[s] = it.drop ? PH_DROPPED : PH_COMPLETED;
                        r.notify = 1'b1;
                    end
                    p_hold[s] = 1'b0;
                    if (!c_hold[s]) recycle(s);
                end
                OP_CONSUME: if (handle_ok(s, it.generation) && c_hold[s]) begin
                    if (phase[s] == PH_COMPLETED) begin
                        r.outcome     = OC_OK;
                        r.res_payload = payload[s];
                        r.res_status  = status[s];
                    end else if (phase[s] == PH_DROPPED) begin
                        r.outcome    = OC_DROPPED;
                        r.res_status = status[s];
                    end else begin
                        if (phase[s] == PH_PENDING) phase[s] = PH_TIMEOUT;
                        r.outcome = OC_TIMEOUT;
                    end
                    c_hold[s] = 1'b0;
                    if (!p_hold[s]) recycle(s);
                end
                OP_ABANDON: if (handle_ok(s, it.generation) && c_hold[s]) begin
                    r.outcome = OC_OK;
                    if (phase[s] == PH_PENDING) phase[s] = PH_ABANDONED;
                    c_hold[s] = 1'b0;
                    if (!p_hold[s]) recycle(s);
                end
                OP_CANCEL: if (handle_ok(s, it.generation) && p_hold[s] && c_hold[s]) begin
                    r.outcome = OC_OK;
                    recycle(s);
                end
                OP_QUERY: begin
                    r.outcome = OC_OK;
                    r.active = handle_ok(s, it.generation) && p_hold[s] && c_hold[s]
                               && phase[s] == PH_PENDING;
                end
                default: ;
            endcase
            expected_results.push_back(r);
        endfunction

        function void check_result(t_out got);
            t_out e;
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer: %p", got);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (got.outcome !== e.outcome) begin
                $error("outcome: expected %0d, actual %0d", e.outcome, got.outcome);
                errors++;
            end
            if (got.out_slot !== e.out_slot) begin
                $error("out_slot: expected %0d, actual %0d", e.out_slot, got.out_slot);
                errors++;
            end
            if (got.out_generation !== e.out_generation) begin
                $error("out_generation: expected %0d, actual %0d",
                       e.out_generation, got.out_generation);
                errors++;
            end
            if (got.res_payload !== e.res_payload) begin
                $error("res_payload: expected %h, actual %h", e.res_payload, got.res_payload);
                errors++;
            end
            if (got.res_status !== e.res_status) begin
                $error("res_status: expected %h, actual %h", e.res_status, got.res_status);
                errors++;
            end
            if (got.notify !== e.notify) begin
                $error("notify: expected %b, actual %b", e.notify, got.notify);
                errors++;
            end
            if (got.active !== e.active) begin
                $error("active: expected %b, actual %b", e.active, got.active);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_in        i_data;
    logic       o_valid;
    logic       i_stall;
    t_out       o_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [5:0] i_cfg_data;

    slot_table_scoreboard sb;
    int hold_req;
    int hold_seen;
    int hold_left;
    int burst_left;
    bit burst_stall;

    completion_slot_table_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // receiver: check transfers, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) sb.check_result(o_data);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (burst_left == 0) begin
                    burst_stall = ($urandom_range(0, 2) == 0);
                    burst_left  = rand_gap() + 1;
                end
                burst_left--;
                i_stall <= burst_stall;
            end
        end
    end

    task automatic send_item(t_in it);
        int gap;
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(it);
        gap = rand_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_count(logic [5:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.slot_count = v;
    endtask

    function automatic t_in mk(t_op op, int s, logic [7:0] g, logic [31:0] pay,
                               logic [31:0] st, logic d);
        t_in it;
        it.op          = op;
        it.slot        = s[4:0];
        it.generation  = g;
        it.payload     = pay;
        it.status_word = st;
        it.drop        = d;
        return it;
    endfunction

    // mostly current-generation handles of usable slots; the rest stale, zero, random or out of range
    function automatic t_in rand_item(int create_weight);
        t_in it;
        int  n;
        int  s;
        int  r;
        it.payload     = $urandom;
        it.status_word = $urandom;
        it.drop        = 1'($urandom_range(0, 1));
        n = sb.usable();
        s = (n > 0 && $urandom_range(0, 9) < 9) ? $urandom_range(0, n - 1)
                                                : $urandom_range(0, 31);
        it.slot = s[4:0];
        r = $urandom_range(0, 99);
        if (r < 80) it.generation = sb.slot_gen[s];
        else if (r < 85) it.generation = 8'd0;
        else if (r < 92) it.generation = sb.slot_gen[s] - 8'd1;
        else it.generation = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < create_weight) it.op = OP_CREATE;
        else if (r < 97) it.op = t_op'($urandom_range(1, 5));
        else it.op = t_op'($urandom_range(6, 7));
        return it;
    endfunction

    task automatic random_phase(int count, int create_weight);
        repeat (count) send_item(rand_item(create_weight));
    endtask

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        hold_req    = 0;
        hold_seen   = 0;
        hold_left   = 0;
        burst_left  = 0;
        burst_stall = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: complete, drop, timeout with late resolve, abandon, cancel, invalid handles and ops, full table
        send_item(mk(OP_CREATE, 0, 0, 0, 0, 0));
        send_item(mk(OP_QUERY, 0, 1, 0, 0, 0));
        send_item(mk(OP_RESOLVE, 0, 1, 32'hFFFF_FFFF, 32'h8000_0000, 0));
        send_item(mk(OP_CONSUME, 0, 1, 0, 0, 0));
        send_item(mk(OP_CREATE, 0, 0, 0, 0, 0));
        send_item(mk(OP_RESOLVE, 0, 2, 32'h0, 32'h7FFF_FFFF, 1));
        send_item(mk(OP_CONSUME, 0, 2, 0, 0, 0));
        send_item(mk(OP_CREATE, 0, 0, 0, 0, 0));
        send_item(mk(OP_CONSUME, 0, 3, 0, 0, 0));
        send_item(mk(OP_RESOLVE, 0, 3, 32'h1234_5678, 32'hFFFF_FFFF, 0));
        send_item(mk(OP_CREATE, 0, 0, 0, 0, 0));
        send_item(mk(OP_ABANDON, 0, 4, 0, 0, 0));
        send_item(mk(OP_RESOLVE, 0, 4, 32'h0, 32'h0, 1));
        send_item(mk(OP_CREATE, 0, 0, 0, 0, 0));
        send_item(mk(OP_CANCEL, 0, 5, 0, 0, 0));
        send_item(mk(OP_CANCEL, 0, 5, 0, 0, 0));
        send_item(mk(OP_QUERY, 0, 0, 0, 0, 0));
        send_item(mk(OP_CONSUME, 31, 1, 0, 0, 0));
        send_item(mk(t_op'(3'd6), 0, 6, 0, 0, 0));
        send_item(mk(t_op'(3'd7), 31, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
        write_count(6'd1);
        send_item(mk(OP_CREATE, 0, 0, 0, 0, 0));
        send_item(mk(OP_CREATE, 0, 0, 0, 0, 0));
        send_item(mk(OP_QUERY, 1, 1, 0, 0, 0));

        // long receiver hold-off while the sender keeps offering
        write_count(6'd32);
        hold_req++;
        random_phase(120, 35);
        // single slot: frequent create and recycle of one slot
        write_count(6'd1);
        random_phase(270, 40);
        write_count(6'd0);
        random_phase(20, 40);
        write_count(6'd63);
        random_phase(60, 30);
        write_count(6'($urandom_range(2, 31)));
        random_phase(60, 30);
        drain();

        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* completion_slot_table_top.f */
rtl/cst_pkg.sv
rtl/completion_slot_table_top.sv
verif/tb.sv
